[src/dmrt_pkg.sv]
// Shared types, constants and arithmetic helpers of the D2Q9 MRT moment relaxation unit.
package dmrt_pkg;

   localparam int NUM_DIRECTIONS = 9;

   // Moment order on the result channel
   typedef enum logic [3:0] {
      MOM_RHO,
      MOM_E,
      MOM_EPS,
      MOM_JX,
      MOM_QX,
      MOM_JY,
      MOM_QY,
      MOM_PXX,
      MOM_PXY
   } moment_type;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RATE_FLUX  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RATE_SHEAR = 2'd1;

   localparam int RATE_W = 26;
   localparam logic [RATE_W-1:0] RATE_UNITY          = 26'd16777216;
   localparam logic [RATE_W-1:0] RATE_ONE_POINT_FOUR = 26'd23488102;

   localparam logic signed [63:0] WORD_MAX   = 64'sd2147483647;
   localparam logic signed [63:0] WORD_MIN   = -64'sd2147483648;
   localparam logic signed [63:0] ROUND_HALF = 64'sd8388608;

   // Integer transform matrix, row = moment, column = direction
   localparam logic signed [3:0] XFORM [NUM_DIRECTIONS][NUM_DIRECTIONS] = '{
      '{ 4'sd1,  4'sd1,  4'sd1,  4'sd1,  4'sd1,  4'sd1,  4'sd1,  4'sd1,  4'sd1},
      '{-4'sd4, -4'sd1, -4'sd1, -4'sd1, -4'sd1,  4'sd2,  4'sd2,  4'sd2,  4'sd2},
      '{ 4'sd4, -4'sd2, -4'sd2, -4'sd2, -4'sd2,  4'sd1,  4'sd1,  4'sd1,  4'sd1},
      '{ 4'sd0,  4'sd1,  4'sd0, -4'sd1,  4'sd0,  4'sd1, -4'sd1, -4'sd1,  4'sd1},
      '{ 4'sd0, -4'sd2,  4'sd0,  4'sd2,  4'sd0,  4'sd1, -4'sd1, -4'sd1,  4'sd1},
      '{ 4'sd0,  4'sd0,  4'sd1,  4'sd0, -4'sd1,  4'sd1,  4'sd1, -4'sd1, -4'sd1},
      '{ 4'sd0,  4'sd0, -4'sd2,  4'sd0,  4'sd2,  4'sd1,  4'sd1, -4'sd1, -4'sd1},
      '{ 4'sd0,  4'sd1, -4'sd1,  4'sd1, -4'sd1,  4'sd0,  4'sd0,  4'sd0,  4'sd0},
      '{ 4'sd0,  4'sd0,  4'sd0,  4'sd0,  4'sd0,  4'sd1, -4'sd1,  4'sd1, -4'sd1}
   };

   typedef struct packed {
      logic signed [31:0] f_rest;
      logic signed [31:0] f_east;
      logic signed [31:0] f_north;
      logic signed [31:0] f_west;
      logic signed [31:0] f_south;
      logic signed [31:0] f_northeast;
      logic signed [31:0] f_northwest;
      logic signed [31:0] f_southwest;
      logic signed [31:0] f_southeast;
      logic signed [31:0] density;
      logic signed [31:0] velocity_x;
      logic signed [31:0] velocity_y;
   } req_type;

   typedef struct packed {
      logic [3:0]         moment_index;
      logic signed [31:0] moment_value;
      logic signed [31:0] equilibrium_value;
      logic signed [31:0] relaxed_difference;
      logic               last;
   } rsp_type;

   typedef struct packed {
      moment_type moment;
      req_type    node;
   } job_type;

   typedef struct packed {
      logic [RATE_W-1:0] rate_flux;
      logic [RATE_W-1:0] rate_shear;
   } rate_cfg_type;

   // Clamp to the signed 32-bit range
   function automatic logic signed [31:0] sat_word(input logic signed [63:0] x);
      logic signed [31:0] r;
      priority if (x > WORD_MAX) begin
         r = WORD_MAX[31:0];
      end else if (x < WORD_MIN) begin
         r = WORD_MIN[31:0];
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

   // Round half up and drop 24 fraction bits of a Q8.24 product
   function automatic logic signed [39:0] round_q(input logic signed [63:0] p);
      logic signed [63:0] t;
      t = p + ROUND_HALF;
      return t[63:24];
   endfunction

   // One term of a transform row: coefficients are 0, +-1, +-2 or +-4
   function automatic logic signed [34:0] xform_term(input logic signed [3:0] c,
                                                     input logic signed [31:0] f);
      logic signed [34:0] fx;
      logic signed [34:0] r;
      fx = 35'(f);
      unique case (c)
         4'sd1:   r = fx;
         -4'sd1:  r = -fx;
         4'sd2:   r = fx <<< 1;
         -4'sd2:  r = -(fx <<< 1);
         4'sd4:   r = fx <<< 2;
         -4'sd4:  r = -(fx <<< 2);
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

[src/dmrt_datapath.sv]
// Nine-stage arithmetic pipeline: one moment, equilibrium and relaxed difference per job.
module dmrt_datapath import dmrt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  logic         job_valid,
   input  job_type      job,
   input  rate_cfg_type rates,
   output logic         res_valid,
   output rsp_type      res
);

   localparam logic signed [35:0] FAC_ONE = 36'sd16777216;
   localparam logic signed [35:0] FAC_TWO = 36'sd33554432;

   logic signed [31:0] f_vec [NUM_DIRECTIONS];
   logic signed [31:0] mul_a;
   logic signed [31:0] mul_b;
   logic signed [35:0] tri_base;

   // stage 1: products and moment partial sums
   logic               v1_ff;
   moment_type         k1_ff;
   logic signed [63:0] p1_ff, p1_in;
   logic signed [63:0] p2_ff, p2_in;
   logic signed [36:0] suma_ff, suma_in;
   logic signed [36:0] sumb_ff, sumb_in;
   logic signed [31:0] rho1_ff;
   // stage 2: rounded products, moment
   logic               v2_ff;
   moment_type         k2_ff;
   logic signed [39:0] r1_ff, r1_in;
   logic signed [39:0] r2_ff, r2_in;
   logic signed [31:0] mom2_ff, mom2_in;
   logic signed [31:0] rho2_ff;
   // stage 3: velocity base, direct equilibria
   logic               v3_ff;
   moment_type         k3_ff;
   logic signed [31:0] base3_ff, base3_in;
   logic signed [31:0] eqd3_ff, eqd3_in;
   logic signed [31:0] mom3_ff;
   logic signed [31:0] rho3_ff;
   // stage 4: density factor
   logic               v4_ff;
   moment_type         k4_ff;
   logic signed [31:0] fac4_ff, fac4_in;
   logic signed [31:0] eqd4_ff;
   logic signed [31:0] mom4_ff;
   logic signed [31:0] rho4_ff;
   // stage 5: density times factor
   logic               v5_ff;
   moment_type         k5_ff;
   logic signed [63:0] p5_ff, p5_in;
   logic signed [31:0] eqd5_ff;
   logic signed [31:0] mom5_ff;
   // stage 6: equilibrium
   logic               v6_ff;
   moment_type         k6_ff;
   logic signed [31:0] eq6_ff, eq6_in;
   logic signed [31:0] mom6_ff;
   // stage 7: non-equilibrium part and rate
   logic               v7_ff;
   moment_type         k7_ff;
   logic signed [32:0] diff7_ff, diff7_in;
   logic [RATE_W-1:0]  rate7_ff, rate7_in;
   logic signed [31:0] mom7_ff;
   logic signed [31:0] eq7_ff;
   // stage 8: rate times difference
   logic               v8_ff;
   moment_type         k8_ff;
   logic signed [63:0] p8_ff, p8_in;
   logic signed [31:0] mom8_ff;
   logic signed [31:0] eq8_ff;
   // stage 9: result register
   logic               res_valid_ff;
   rsp_type            res_ff, res_in;

   assign f_vec[0] = job.node.f_rest;
   assign f_vec[1] = job.node.f_east;
   assign f_vec[2] = job.node.f_north;
   assign f_vec[3] = job.node.f_west;
   assign f_vec[4] = job.node.f_south;
   assign f_vec[5] = job.node.f_northeast;
   assign f_vec[6] = job.node.f_northwest;
   assign f_vec[7] = job.node.f_southwest;
   assign f_vec[8] = job.node.f_southeast;

   // stage 1
   always_comb begin
      unique case (job.moment)
         MOM_E, MOM_EPS, MOM_PXX: begin
            mul_a = job.node.velocity_x;
            mul_b = job.node.velocity_x;
         end
         MOM_PXY: begin
            mul_a = job.node.velocity_x;
            mul_b = job.node.velocity_y;
         end
         MOM_JX, MOM_QX: begin
            mul_a = job.node.density;
            mul_b = job.node.velocity_x;
         end
         MOM_JY, MOM_QY: begin
            mul_a = job.node.density;
            mul_b = job.node.velocity_y;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      p1_in = 64'(mul_a) * 64'(mul_b);
      p2_in = 64'(job.node.velocity_y) * 64'(job.node.velocity_y);
      suma_in = '0;
      for (int i = 0; i < 5; i++) begin
         suma_in = suma_in + 37'(xform_term(XFORM[job.moment][i], f_vec[i]));
      end
      sumb_in = '0;
      for (int i = 5; i < NUM_DIRECTIONS; i++) begin
         sumb_in = sumb_in + 37'(xform_term(XFORM[job.moment][i], f_vec[i]));
      end
   end

   // stage 2
   always_comb begin
      r1_in   = round_q(p1_ff);
      r2_in   = round_q(p2_ff);
      mom2_in = sat_word(64'(suma_ff + sumb_ff));
   end

   // stage 3
   always_comb begin
      unique case (k2_ff)
         MOM_E, MOM_EPS: base3_in = sat_word(64'(41'(r1_ff) + 41'(r2_ff)));
         MOM_PXX:        base3_in = sat_word(64'(41'(r1_ff) - 41'(r2_ff)));
         MOM_PXY:        base3_in = sat_word(64'(r1_ff));
         default:        base3_in = '0;
      endcase
      unique case (k2_ff)
         MOM_RHO:        eqd3_in = rho2_ff;
         MOM_JX, MOM_JY: eqd3_in = sat_word(64'(r1_ff));
         MOM_QX, MOM_QY: eqd3_in = sat_word(-64'(r1_ff));
         default:        eqd3_in = '0;
      endcase
   end

   // stage 4
   always_comb begin
      tri_base = 36'(base3_ff) + (36'(base3_ff) <<< 1);
      unique case (k3_ff)
         MOM_E:   fac4_in = sat_word(64'(tri_base - FAC_TWO));
         MOM_EPS: fac4_in = sat_word(64'(FAC_ONE - tri_base));
         default: fac4_in = base3_ff;
      endcase
   end

   // stage 5
   assign p5_in = 64'(rho4_ff) * 64'(fac4_ff);

   // stage 6
   always_comb begin
      unique case (k5_ff)
         MOM_E, MOM_EPS, MOM_PXX, MOM_PXY: eq6_in = sat_word(64'(round_q(p5_ff)));
         default:                          eq6_in = eqd5_ff;
      endcase
   end

   // stage 7
   always_comb begin
      diff7_in = 33'(mom6_ff) - 33'(eq6_ff);
      unique case (k6_ff)
         MOM_E, MOM_EPS:   rate7_in = RATE_ONE_POINT_FOUR;
         MOM_QX, MOM_QY:   rate7_in = rates.rate_flux;
         MOM_PXX, MOM_PXY: rate7_in = rates.rate_shear;
         default:          rate7_in = RATE_UNITY;
      endcase
   end

   // stage 8
   assign p8_in = 64'(diff7_ff) * 64'($signed({1'b0, rate7_ff}));

   // stage 9
   always_comb begin
      res_in.moment_index       = k8_ff;
      res_in.moment_value       = mom8_ff;
      res_in.equilibrium_value  = eq8_ff;
      res_in.relaxed_difference = sat_word(64'(round_q(p8_ff)));
      res_in.last               = (k8_ff == MOM_PXY);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         v6_ff        <= 1'b0;
         v7_ff        <= 1'b0;
         v8_ff        <= 1'b0;
         res_valid_ff <= 1'b0;
      end else if (advance) begin
         v1_ff        <= job_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         v5_ff        <= v4_ff;
         v6_ff        <= v5_ff;
         v7_ff        <= v6_ff;
         v8_ff        <= v7_ff;
         res_valid_ff <= v8_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         k1_ff    <= job.moment;
         p1_ff    <= p1_in;
         p2_ff    <= p2_in;
         suma_ff  <= suma_in;
         sumb_ff  <= sumb_in;
         rho1_ff  <= job.node.density;

         k2_ff    <= k1_ff;
         r1_ff    <= r1_in;
         r2_ff    <= r2_in;
         mom2_ff  <= mom2_in;
         rho2_ff  <= rho1_ff;

         k3_ff    <= k2_ff;
         base3_ff <= base3_in;
         eqd3_ff  <= eqd3_in;
         mom3_ff  <= mom2_ff;
         rho3_ff  <= rho2_ff;

         k4_ff    <= k3_ff;
         fac4_ff  <= fac4_in;
         eqd4_ff  <= eqd3_ff;
         mom4_ff  <= mom3_ff;
         rho4_ff  <= rho3_ff;

         k5_ff    <= k4_ff;
         p5_ff    <= p5_in;
         eqd5_ff  <= eqd4_ff;
         mom5_ff  <= mom4_ff;

         k6_ff    <= k5_ff;
         eq6_ff   <= eq6_in;
         mom6_ff  <= mom5_ff;

         k7_ff    <= k6_ff;
         diff7_ff <= diff7_in;
         rate7_ff <= rate7_in;
         mom7_ff  <= mom6_ff;
         eq7_ff   <= eq6_ff;

         k8_ff    <= k7_ff;
         p8_ff    <= p8_in;
         mom8_ff  <= mom7_ff;
         eq8_ff   <= eq7_ff;

         res_ff   <= res_in;
      end
   end

   assign res_valid = res_valid_ff;
   assign res       = res_ff;

endmodule

[src/d2q9_mrt_moment_relaxation_unit.sv]
// Top level of the D2Q9 MRT moment relaxation unit: node intake, rate registers, pipeline.
//
// Each request transaction carries one D2Q9 lattice node (nine distributions, density and
// velocity, all signed Q8.24). The unit answers with nine response transactions in moment
// order rho, e, eps, jx, qx, jy, qy, pxx, pxy, the ninth marked last; each carries the
// moment, its equilibrium and the relaxed difference rate * (moment - equilibrium), all
// saturated to Q8.24. The node register issues one moment job per cycle, while the response
// side does not stall, into a nine-stage arithmetic pipeline. The single-result response
// port carries one moment at a time; a new node is accepted as the last moment of the
// previous one issues, while earlier nodes are still in flight. A stall on the response
// side freezes the whole pipeline and the issuer; nothing is dropped or repeated.
// The shear and heat-flux rates are written through the csr port (index 0: rate_flux,
// index 1: rate_shear, other indexes ignored) and must only change while the unit is idle.
module d2q9_mrt_moment_relaxation_unit import dmrt_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_payload,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [RATE_W-1:0]      csr_data
);

   logic         advance;
   logic         issue;
   logic         req_take;
   logic         node_valid_ff, node_valid_in;
   moment_type   idx_ff, idx_in;
   req_type      node_ff, node_in;
   rate_cfg_type rate_cfg_ff, rate_cfg_in;
   job_type      job;

   // Hold the pipeline and the issuer while a result sits in the output register and is stalled
   assign advance = !(rsp_valid && rsp_stall);
   assign issue   = node_valid_ff && advance;

   // Take a new node when the register is empty or its last moment leaves this cycle
   assign req_stall = node_valid_ff && !(issue && (idx_ff == MOM_PXY));
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      node_valid_in = node_valid_ff;
      idx_in        = idx_ff;
      node_in       = node_ff;
      if (req_take) begin
         node_valid_in = 1'b1;
         idx_in        = MOM_RHO;
         node_in       = req_payload;
      end else if (issue) begin
         if (idx_ff == MOM_PXY) begin
            node_valid_in = 1'b0;
         end else begin
            idx_in = moment_type'(idx_ff + 4'd1);
         end
      end
   end

   // Rate registers; unknown indexes drop the write
   always_comb begin
      rate_cfg_in = rate_cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_RATE_FLUX:  rate_cfg_in.rate_flux  = csr_data;
            CSR_RATE_SHEAR: rate_cfg_in.rate_shear = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_valid_ff          <= 1'b0;
         idx_ff                 <= MOM_RHO;
         rate_cfg_ff.rate_flux  <= RATE_UNITY;
         rate_cfg_ff.rate_shear <= RATE_UNITY;
      end else begin
         node_valid_ff <= node_valid_in;
         idx_ff        <= idx_in;
         rate_cfg_ff   <= rate_cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff <= node_in;
   end

   assign job.moment = idx_ff;
   assign job.node   = node_ff;

   dmrt_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .job_valid (node_valid_ff),
      .job       (job),
      .rates     (rate_cfg_ff),
      .res_valid (rsp_valid),
      .res       (rsp_payload)
   );

   // A freshly accepted node starts at the density moment
   a_take_starts_rho: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (node_valid_ff && (idx_ff == MOM_RHO)))
      else $error("accepted node does not start at moment rho");

   // An empty node register never pushes back on the request side
   a_empty_no_stall: assert property (@(posedge clock) disable iff (reset)
      !node_valid_ff |-> !req_stall)
      else $error("request stalled with empty node register");

   // A stalled response freezes the issuer
   a_stall_freezes_issue: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall && node_valid_ff) |=> (node_valid_ff && $stable(idx_ff)))
      else $error("issuer moved under response stall");

   // Rate_flux writes land in the register
   a_flux_write: assert property (@(posedge clock) disable iff (reset)
      (csr_write && (csr_index == CSR_RATE_FLUX)) |=> (rate_cfg_ff.rate_flux == $past(csr_data)))
      else $error("rate_flux write lost");

endmodule

[dv/d2q9_mrt_moment_checker.sv]
// Response predictor and scoreboard for the D2Q9 MRT moment relaxation unit.
module d2q9_mrt_moment_checker import dmrt_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  req_type                req_payload,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  rsp_type                rsp_payload,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [RATE_W-1:0]      csr_data,
   output int                     mismatch_count,
   output int                     results_pending,
   output int                     results_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint UNIT = 64'sd16777216;

   logic [RATE_W-1:0] flux_rate;
   logic [RATE_W-1:0] shear_rate;
   rsp_type           expected_moments[$];

   initial begin
      mismatch_count  = 0;
      results_pending = 0;
      results_checked = 0;
   end

   function automatic longint clamp_word(input longint x);
      if (x > WORD_MAX) begin
         return WORD_MAX;
      end else if (x < WORD_MIN) begin
         return WORD_MIN;
      end
      return x;
   endfunction

   // Q8.24 product, rounded half up (arithmetic shift is a floor)
   function automatic longint fix_mul(input longint a, input longint b);
      return (a * b + 64'sd8388608) >>> 24;
   endfunction

   task automatic predict_node(input req_type n);
      longint f [NUM_DIRECTIONS];
      longint mom [NUM_DIRECTIONS];
      longint eqm [NUM_DIRECTIONS];
      longint rate [NUM_DIRECTIONS];
      longint rho, ux, uy, uu, vv, uv, usq, jx, jy, sides, corners;
      rsp_type item;
      f[0] = $signed(n.f_rest);
      f[1] = $signed(n.f_east);
      f[2] = $signed(n.f_north);
      f[3] = $signed(n.f_west);
      f[4] = $signed(n.f_south);
      f[5] = $signed(n.f_northeast);
      f[6] = $signed(n.f_northwest);
      f[7] = $signed(n.f_southwest);
      f[8] = $signed(n.f_southeast);
      rho = $signed(n.density);
      ux  = $signed(n.velocity_x);
      uy  = $signed(n.velocity_y);

      sides   = f[1] + f[2] + f[3] + f[4];
      corners = f[5] + f[6] + f[7] + f[8];
      mom[MOM_RHO] = clamp_word(f[0] + sides + corners);
      mom[MOM_E]   = clamp_word(-4 * f[0] - sides + 2 * corners);
      mom[MOM_EPS] = clamp_word(4 * f[0] - 2 * sides + corners);
      mom[MOM_JX]  = clamp_word(f[1] - f[3] + f[5] - f[6] - f[7] + f[8]);
      mom[MOM_QX]  = clamp_word(-2 * f[1] + 2 * f[3] + f[5] - f[6] - f[7] + f[8]);
      mom[MOM_JY]  = clamp_word(f[2] - f[4] + f[5] + f[6] - f[7] - f[8]);
      mom[MOM_QY]  = clamp_word(-2 * f[2] + 2 * f[4] + f[5] + f[6] - f[7] - f[8]);
      mom[MOM_PXX] = clamp_word(f[1] - f[2] + f[3] - f[4]);
      mom[MOM_PXY] = clamp_word(f[5] - f[6] + f[7] - f[8]);

      uu  = fix_mul(ux, ux);
      vv  = fix_mul(uy, uy);
      uv  = fix_mul(ux, uy);
      usq = clamp_word(uu + vv);
      jx  = fix_mul(rho, ux);
      jy  = fix_mul(rho, uy);
      eqm[MOM_RHO] = rho;
      eqm[MOM_E]   = clamp_word(fix_mul(rho, clamp_word(3 * usq - 2 * UNIT)));
      eqm[MOM_EPS] = clamp_word(fix_mul(rho, clamp_word(UNIT - 3 * usq)));
      eqm[MOM_JX]  = clamp_word(jx);
      eqm[MOM_QX]  = clamp_word(-jx);
      eqm[MOM_JY]  = clamp_word(jy);
      eqm[MOM_QY]  = clamp_word(-jy);
      eqm[MOM_PXX] = clamp_word(fix_mul(rho, clamp_word(uu - vv)));
      eqm[MOM_PXY] = clamp_word(fix_mul(rho, clamp_word(uv)));

      rate[MOM_RHO] = RATE_UNITY;
      rate[MOM_E]   = RATE_ONE_POINT_FOUR;
      rate[MOM_EPS] = RATE_ONE_POINT_FOUR;
      rate[MOM_JX]  = RATE_UNITY;
      rate[MOM_QX]  = flux_rate;
      rate[MOM_JY]  = RATE_UNITY;
      rate[MOM_QY]  = flux_rate;
      rate[MOM_PXX] = shear_rate;
      rate[MOM_PXY] = shear_rate;

      for (int k = 0; k < NUM_DIRECTIONS; k++) begin
         item.moment_index       = 4'(k);
         item.moment_value       = 32'(mom[k]);
         item.equilibrium_value  = 32'(eqm[k]);
         item.relaxed_difference = 32'(clamp_word(fix_mul(rate[k], mom[k] - eqm[k])));
         item.last               = (k == MOM_PXY);
         expected_moments.push_back(item);
      end
   endtask

   // Print one line per mismatch and count it.
   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      $display("mismatch at node %0d moment %0d, %s: got %h want %h",
               results_checked / NUM_DIRECTIONS, results_checked % NUM_DIRECTIONS,
               what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         flux_rate  = RATE_UNITY;
         shear_rate = RATE_UNITY;
         expected_moments.delete();
      end else begin
         if (csr_write) begin
            if (csr_index == CSR_RATE_FLUX) begin
               flux_rate = csr_data;
            end else if (csr_index == CSR_RATE_SHEAR) begin
               shear_rate = csr_data;
            end
         end
         if (req_valid && !req_stall) begin
            predict_node(req_payload);
         end
         if (rsp_valid && !rsp_stall) begin
            got = rsp_payload;
            if (expected_moments.size() == 0) begin
               flag_mismatch("response with nothing outstanding", 32'(got.moment_index), '0);
            end else begin
               want = expected_moments.pop_front();
               if (got.moment_index !== want.moment_index) begin
                  flag_mismatch("moment_index", 32'(got.moment_index),
                                32'(want.moment_index));
               end
               if (got.moment_value !== want.moment_value) begin
                  flag_mismatch("moment_value", got.moment_value, want.moment_value);
               end
               if (got.equilibrium_value !== want.equilibrium_value) begin
                  flag_mismatch("equilibrium_value", got.equilibrium_value,
                                want.equilibrium_value);
               end
               if (got.relaxed_difference !== want.relaxed_difference) begin
                  flag_mismatch("relaxed_difference", got.relaxed_difference,
                                want.relaxed_difference);
               end
               if (got.last !== want.last) begin
                  flag_mismatch("last", 32'(got.last), 32'(want.last));
               end
            end
            results_checked++;
         end
      end
      results_pending = expected_moments.size();
   end

endmodule

[dv/d2q9_mrt_moment_relaxation_unit_tb.sv]
// Testbench top of the D2Q9 MRT moment relaxation unit: clock, reset, stimulus and verdict.
module d2q9_mrt_moment_relaxation_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import dmrt_pkg::*;

   // Run shape
   localparam int RATE_PHASES     = 6;
   localparam int NODES_PER_PHASE = 65;   // about 390 random nodes in all
   localparam int DRAIN_CYCLES    = 40;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int LAST_FIELD      = $bits(req_type) / 32 - 1;

   // Register indexes the unit does not decode
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_B = 2'd3;

   // Q8.24 corner words and rate extremes
   localparam logic [31:0] Q_ONE       = 32'h0100_0000;
   localparam logic [31:0] WORD_TOP    = 32'h7fff_ffff;
   localparam logic [31:0] WORD_BOTTOM = 32'h8000_0000;
   localparam logic [RATE_W-1:0] RATE_ZERO = '0;
   localparam logic [RATE_W-1:0] RATE_TWO  = 26'd33554432;
   localparam logic [RATE_W-1:0] RATE_TOP  = '1;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   logic                   req_stall;
   req_type                req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_stall   = 1'b0;
   rsp_type                rsp_payload;
   logic                   csr_write   = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index   = CSR_RATE_FLUX;
   logic [RATE_W-1:0]      csr_data    = RATE_UNITY;

   int mismatch_count;
   int results_pending;
   int results_checked;
   int nodes_sent  = 0;
   int burst_left  = 0;
   int cycle_count = 0;
   int stall_left  = 0;
   stall_mode_type stall_mode = STALL_NONE;

   always #1 clock = ~clock;

   d2q9_mrt_moment_relaxation_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   // The checker watches both channels and the register port; it owns the prediction.
   d2q9_mrt_moment_checker moments_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_payload     (rsp_payload),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .mismatch_count  (mismatch_count),
      .results_pending (results_pending),
      .results_checked (results_checked)
   );

   // Hard stop: a hung handshake or a lost response ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Response-side back-pressure: switch between free flow, light and heavy random
   // stalls and a periodic hold, each for a random stretch, so stalls hit every
   // position of the nine-result train.
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_left = $urandom_range(20, 200);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 99) < 30);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 99) < 75);
         default:     rsp_stall <= ((stall_left % 23) < 8);
      endcase
   end

   // Offer one node and hold it until the unit takes it. Afterwards either keep valid
   // high for the next transaction of the burst or drop it for a random gap.
   task automatic send_node(input req_type n);
      int gap;
      req_payload <= n;
      req_valid   <= 1'b1;
      do @(posedge clock); while (req_stall);
      nodes_sent++;
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 24);
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 10);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   // Drop valid, let every expected response come back, then let the pipe settle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (results_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_rate(input logic [CSR_INDEX_W-1:0] index, input logic [RATE_W-1:0] value);
      csr_index <= index;
      csr_data  <= value;
      csr_write <= 1'b1;
      @(negedge clock);
      csr_write <= 1'b0;
      @(negedge clock);
   endtask

   // All nine distributions alike; density and velocity given separately.
   function automatic req_type uniform_node(input logic [31:0] fval, input logic [31:0] rho,
                                            input logic [31:0] ux, input logic [31:0] uy);
      req_type n;
      for (int i = 0; i < NUM_DIRECTIONS; i++) begin
         n[(LAST_FIELD - i) * 32 +: 32] = fval;
      end
      n.density    = rho;
      n.velocity_x = ux;
      n.velocity_y = uy;
      return n;
   endfunction

   function automatic logic [31:0] corner_word();
      case ($urandom_range(0, 5))
         0:       return WORD_TOP;
         1:       return WORD_BOTTOM;
         2:       return '0;
         3:       return Q_ONE;
         4:       return -Q_ONE;
         default: return $urandom();
      endcase
   endfunction

   // Mostly near-equilibrium nodes (density near 1, small velocity, distributions near
   // the lattice weights), then full-range noise and corner-word mixes.
   function automatic req_type random_node();
      req_type n;
      int pick;
      int rho;
      int wt;
      int noise;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         rho          = 16777216 + int'($urandom_range(0, 8388608)) - 4194304;
         n.density    = rho;
         n.velocity_x = int'($urandom_range(0, 6710886)) - 3355443;
         n.velocity_y = int'($urandom_range(0, 6710886)) - 3355443;
         for (int i = 0; i < NUM_DIRECTIONS; i++) begin
            wt    = (i == 0) ? 16 : (i < 5) ? 4 : 1;
            noise = int'($urandom_range(0, 2097152)) - 1048576;
            n[(LAST_FIELD - i) * 32 +: 32] = 32'((longint'(rho) * wt) / 36 + noise);
         end
      end else if (pick < 80) begin
         for (int i = 0; i <= LAST_FIELD; i++) begin
            n[i * 32 +: 32] = $urandom();
         end
      end else begin
         for (int i = 0; i <= LAST_FIELD; i++) begin
            n[i * 32 +: 32] = corner_word();
         end
      end
      return n;
   endfunction

   initial begin
      req_type n;
      logic [RATE_W-1:0] flux;
      logic [RATE_W-1:0] shear;

      // Hold reset, then release it for good.
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed nodes under the reset rates (both 1.0).
      send_node(uniform_node('0, '0, '0, '0));
      send_node(uniform_node(WORD_TOP, WORD_TOP, WORD_TOP, WORD_TOP));
      send_node(uniform_node(WORD_BOTTOM, WORD_BOTTOM, WORD_BOTTOM, WORD_BOTTOM));
      // Rest against sides against corners: drive e and eps into both clamps.
      n = uniform_node(WORD_TOP, WORD_TOP, WORD_BOTTOM, WORD_TOP);
      n.f_east = WORD_BOTTOM; n.f_north = WORD_BOTTOM;
      n.f_west = WORD_BOTTOM; n.f_south = WORD_BOTTOM;
      send_node(n);
      n = uniform_node(WORD_BOTTOM, WORD_BOTTOM, WORD_TOP, WORD_BOTTOM);
      n.f_east = WORD_TOP; n.f_north = WORD_TOP;
      n.f_west = WORD_TOP; n.f_south = WORD_TOP;
      send_node(n);
      // East-going against west-going: saturate jx, with qx and pxy cancelling to zero.
      n = uniform_node(WORD_BOTTOM, Q_ONE, Q_ONE, -Q_ONE);
      n.f_west = WORD_TOP; n.f_northwest = WORD_TOP; n.f_southwest = WORD_TOP;
      send_node(n);
      // Alternating bit patterns.
      n = uniform_node(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa);
      n.f_north = 32'haaaa_aaaa; n.f_south = 32'haaaa_aaaa; n.f_northwest = 32'haaaa_aaaa;
      send_node(n);
      // Fluid at rest on the lattice weights, then a slowly moving node.
      n = uniform_node(32'd466034, Q_ONE, '0, '0);
      n.f_rest = 32'd7456540;
      n.f_east = 32'd1864135; n.f_north = 32'd1864135;
      n.f_west = 32'd1864135; n.f_south = 32'd1864135;
      send_node(n);
      n.velocity_x = 32'd1677722;
      n.velocity_y = -32'd838861;
      send_node(n);
      // Rounding at exact halves, positive and negative products.
      send_node(uniform_node(32'h0000_1234, -32'd3, 32'h0080_0000, 32'h0080_0000));
      send_node(uniform_node(32'h0000_0001, 32'd1, 32'h0000_0800, 32'h0000_1000));
      // Negated momentum overflows: -(rho * u) with rho at the bottom word.
      send_node(uniform_node('0, WORD_BOTTOM, Q_ONE, -Q_ONE));
      send_node(uniform_node('0, WORD_BOTTOM, WORD_TOP, WORD_BOTTOM));
      // Huge velocity: u*u clamps the velocity factors.
      send_node(uniform_node(Q_ONE, Q_ONE, WORD_TOP, '0));
      // One unit in each direction, one at a time: exercises each matrix column.
      for (int d = 0; d < NUM_DIRECTIONS; d++) begin
         n = uniform_node('0, Q_ONE, 32'(d) <<< 21, -(32'(d) <<< 20));
         n[(LAST_FIELD - d) * 32 +: 32] = Q_ONE;
         send_node(n);
      end
      wait_idle();

      // Random nodes under a sequence of rate settings, rates only changed while idle.
      for (int phase = 1; phase <= RATE_PHASES; phase++) begin
         case (phase)
            1:       begin flux = RATE_ZERO; shear = RATE_ZERO; end
            2:       begin flux = RATE_TOP;  shear = RATE_TOP;  end
            3:       begin flux = RATE_TWO;  shear = RATE_UNITY; end
            4:       begin flux = RATE_W'($urandom()); shear = RATE_W'($urandom()); end
            5:       begin flux = RATE_W'($urandom()); shear = RATE_ZERO; end
            default: begin flux = 26'd1;     shear = RATE_TWO;  end
         endcase
         write_rate(CSR_RATE_FLUX, flux);
         write_rate(CSR_RATE_SHEAR, shear);
         // Writes to undecoded indexes must leave both rates alone.
         if (phase == 3 || phase == 5) begin
            write_rate(CSR_SPARE_A, RATE_W'($urandom()));
            write_rate(CSR_SPARE_B, RATE_W'($urandom()));
         end
         repeat (NODES_PER_PHASE) send_node(random_node());
         wait_idle();
      end

      $display("covered %0d nodes (directed corners, then random), %0d moment responses checked",
               nodes_sent, results_checked);
      $display("rate settings: reset, zero, 26-bit maximum, 2.0, random; spare indexes written");
      if (mismatch_count == 0 && results_pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
